### design/clock_adaptive_page_replacement_top_assert.svh
// Assertion macros for the CAR page directory.
// Included by the top level; expects signals clock and reset in scope.
`ifndef CLOCK_ADAPTIVE_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define CLOCK_ADAPTIVE_PAGE_REPLACEMENT_TOP_ASSERT_SVH

// Condition holds at every edge out of reset
`define CAPR_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define CAPR_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define CAPR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### design/capr_pkg.sv
// Package for the CAR page directory: list codes, found codes, meta layout, FSM types.
// No dependencies; used by clock_adaptive_page_replacement_top.
package capr_pkg;

   // list codes kept in the meta word
   localparam logic [1:0] LST_T1 = 2'd0;
   localparam logic [1:0] LST_T2 = 2'd1;
   localparam logic [1:0] LST_B1 = 2'd2;
   localparam logic [1:0] LST_B2 = 2'd3;

   // where a page was found
   localparam logic [2:0] FND_NONE = 3'd0;
   localparam logic [2:0] FND_T1   = 3'd1;
   localparam logic [2:0] FND_T2   = 3'd2;
   localparam logic [2:0] FND_B1   = 3'd3;
   localparam logic [2:0] FND_B2   = 3'd4;

   // meta word bit positions: {dirty, ref, list[1:0], valid}
   localparam int META_VALID = 0;
   localparam int META_REF   = 3;
   localparam int META_DIRTY = 4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_SW_SEL,
      ST_RD,
      ST_UNL,
      ST_PUSH,
      ST_AFTER,
      ST_DIV_INIT,
      ST_DIV,
      ST_ALLOC,
      ST_ALLOC_RD,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      OP_SWEEP,
      OP_DROP,
      OP_GHOST,
      OP_ADMIT
   } op_type;

endpackage

### design/clock_adaptive_page_replacement_top.sv
// CAR page directory. A word is taken in idle; its tag scan covers N slots (N = slots used
// since the last flush, at most 2*capacity), then a hit marks the entry and loads the result.
// A miss on full lists runs clock-sweep steps (read, unlink, move to a ghost or T2), checks
// the ghosts, may drop a ghost and takes a slot; a ghost hit divides the ratio, moves it to T2.
// One word at a time: the next word is taken once the result loads; a stalled result holds it.
// Synchronous reset: capacity 256, all lists empty, p and counts zero; no clearing pass.
module clock_adaptive_page_replacement_top #(
   parameter int CAP       = 256,
   parameter int PAGE_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [PAGE_BITS-1:0] req_page,
   input  logic                 req_is_read,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_hit,
   output logic [2:0]           rsp_found_in,
   output logic                 rsp_fetch_from_backing,
   output logic                 rsp_write_through,
   output logic                 rsp_writeback_dirty,
   output logic                 rsp_demoted_valid,
   output logic [31:0]          rsp_demoted_page,
   output logic [8:0]           rsp_target_p,
   output logic [31:0]          rsp_hit_count,
   output logic [31:0]          rsp_request_count,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [8:0]           csr_capacity
);
   import capr_pkg::*;

   localparam int SLOTS = 2 * CAP;
   localparam int IW    = (SLOTS > 2) ? $clog2(SLOTS) : 1;
   localparam int SW    = $clog2(SLOTS + 1);
   localparam int AW    = ((SW > 9) ? SW : 9) + 1;
   localparam int CW    = $clog2(SW + 1);
   localparam logic [8:0]  CAP9   = 9'((CAP > 511) ? 511 : CAP);
   localparam logic [SW-1:0] SLOTS_S = SW'(SLOTS);

   // entry memories
   logic [PAGE_BITS-1:0] tag_mem [SLOTS];
   logic [4:0]           meta_mem [SLOTS];
   logic [IW-1:0]        nxt_mem [SLOTS];
   logic [IW-1:0]        prv_mem [SLOTS];
   logic [IW-1:0]        fs_mem [SLOTS];

   logic [PAGE_BITS-1:0] tag_rd_ff;
   logic [4:0]           meta_rd_ff;
   logic [IW-1:0]        nxt_rd_ff, prv_rd_ff, fs_rd_ff;

   logic                 tag_we, meta_we, nxt_we, prv_we, fs_we;
   logic [IW-1:0]        tag_wa, meta_wa, nxt_wa, prv_wa, fs_wa, raddr;
   logic [4:0]           meta_wd;
   logic [IW-1:0]        nxt_wd, prv_wd, fs_wd;

   // control and list state
   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic                 rd_ff, rd_in;
   logic [2:0]           found_ff, found_in;
   logic [IW-1:0]        slot_ff, slot_in;
   logic [4:0]           bmeta_ff, bmeta_in;
   logic [SW-1:0]        scan_ff, scan_in;
   logic                 cmpv_ff, cmpv_in;
   logic [IW-1:0]        cmpi_ff, cmpi_in;
   logic [IW-1:0]        cur_ff, cur_in;
   logic [1:0]           sl_ff, sl_in;
   logic [1:0]           pl_ff, pl_in;
   logic                 dem_v_ff, dem_v_in, dem_d_ff, dem_d_in;
   logic [PAGE_BITS-1:0] dem_pg_ff, dem_pg_in;
   logic [8:0]           p_ff, p_in;
   logic [31:0]          hits_ff, hits_in, reqs_ff, reqs_in;
   logic [8:0]           cap_ff, cap_in;
   logic [IW-1:0]        head_ff [4], head_in [4];
   logic [IW-1:0]        tail_ff [4], tail_in [4];
   logic [SW-1:0]        size_ff [4], size_in [4];
   logic [SW-1:0]        nu_ff, nu_in, sp_ff, sp_in;
   logic [SW:0]          rem_ff, rem_in;
   logic [SW-1:0]        quo_ff, quo_in, dvs_ff, dvs_in;
   logic [CW-1:0]        dcnt_ff, dcnt_in;

   // result register
   logic                 ov_ff, ov_in;
   logic                 o_hit_ff, o_hit_in, o_fetch_ff, o_fetch_in, o_wt_ff, o_wt_in;
   logic                 o_wb_ff, o_wb_in, o_dv_ff, o_dv_in;
   logic [2:0]           o_found_ff, o_found_in;
   logic [31:0]          o_dp_ff, o_dp_in, o_hc_ff, o_hc_in, o_rc_ff, o_rc_in;
   logic [8:0]           o_p_ff, o_p_in;

   // combinational helpers
   logic [8:0]           c_eff;
   logic [AW-1:0]        c_w, s1_w, s2_w, b1_w, b2_w, sum_w, p_w, d_w, pd_w;
   logic [PAGE_BITS+31:0] dem_ext;
   logic [2:0]           code;
   logic [1:0]           lsel;
   logic [8:0]           thr;
   logic [SW:0]          rem_sh;
   logic [SW-1:0]        qv;

   // effective capacity
   always_comb begin
      if (cap_ff == 9'd0) begin
         c_eff = 9'd1;
      end else if (32'(cap_ff) > 32'(CAP)) begin
         c_eff = CAP9;
      end else begin
         c_eff = cap_ff;
      end
   end

   assign c_w   = AW'(c_eff);
   assign s1_w  = AW'(size_ff[LST_T1]);
   assign s2_w  = AW'(size_ff[LST_T2]);
   assign b1_w  = AW'(size_ff[LST_B1]);
   assign b2_w  = AW'(size_ff[LST_B2]);
   assign sum_w = s1_w + s2_w + b1_w + b2_w;
   assign p_w   = AW'(p_ff);

   // memories: one write per port per cycle, registered read at one shared address
   always_ff @(posedge clock) begin
      if (tag_we)  tag_mem[tag_wa]   <= page_ff;
      if (meta_we) meta_mem[meta_wa] <= meta_wd;
      if (nxt_we)  nxt_mem[nxt_wa]   <= nxt_wd;
      if (prv_we)  prv_mem[prv_wa]   <= prv_wd;
      if (fs_we)   fs_mem[fs_wa]     <= fs_wd;
      tag_rd_ff  <= tag_mem[raddr];
      meta_rd_ff <= meta_mem[raddr];
      nxt_rd_ff  <= nxt_mem[raddr];
      prv_rd_ff  <= prv_mem[raddr];
      fs_rd_ff   <= fs_mem[raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_SWEEP;
         p_ff     <= '0;
         hits_ff  <= '0;
         reqs_ff  <= '0;
         cap_ff   <= 9'd256;
         nu_ff    <= '0;
         sp_ff    <= '0;
         ov_ff    <= 1'b0;
         for (int k = 0; k < 4; k++) begin
            head_ff[k] <= '0;
            tail_ff[k] <= '0;
            size_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         p_ff     <= p_in;
         hits_ff  <= hits_in;
         reqs_ff  <= reqs_in;
         cap_ff   <= cap_in;
         nu_ff    <= nu_in;
         sp_ff    <= sp_in;
         ov_ff    <= ov_in;
         for (int k = 0; k < 4; k++) begin
            head_ff[k] <= head_in[k];
            tail_ff[k] <= tail_in[k];
            size_ff[k] <= size_in[k];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      page_ff    <= page_in;
      rd_ff      <= rd_in;
      found_ff   <= found_in;
      slot_ff    <= slot_in;
      bmeta_ff   <= bmeta_in;
      scan_ff    <= scan_in;
      cmpv_ff    <= cmpv_in;
      cmpi_ff    <= cmpi_in;
      cur_ff     <= cur_in;
      sl_ff      <= sl_in;
      pl_ff      <= pl_in;
      dem_v_ff   <= dem_v_in;
      dem_d_ff   <= dem_d_in;
      dem_pg_ff  <= dem_pg_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      dvs_ff     <= dvs_in;
      dcnt_ff    <= dcnt_in;
      o_hit_ff   <= o_hit_in;
      o_found_ff <= o_found_in;
      o_fetch_ff <= o_fetch_in;
      o_wt_ff    <= o_wt_in;
      o_wb_ff    <= o_wb_in;
      o_dv_ff    <= o_dv_in;
      o_dp_ff    <= o_dp_in;
      o_p_ff     <= o_p_in;
      o_hc_ff    <= o_hc_in;
      o_rc_ff    <= o_rc_in;
   end

   assign dem_ext = {32'd0, dem_pg_ff};

   // next state and datapath
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      page_in  = page_ff;
      rd_in    = rd_ff;
      found_in = found_ff;
      slot_in  = slot_ff;
      bmeta_in = bmeta_ff;
      scan_in  = scan_ff;
      cmpv_in  = 1'b0;
      cmpi_in  = cmpi_ff;
      cur_in   = cur_ff;
      sl_in    = sl_ff;
      pl_in    = pl_ff;
      dem_v_in = dem_v_ff;
      dem_d_in = dem_d_ff;
      dem_pg_in = dem_pg_ff;
      p_in     = p_ff;
      hits_in  = hits_ff;
      reqs_in  = reqs_ff;
      cap_in   = cap_ff;
      nu_in    = nu_ff;
      sp_in    = sp_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      dcnt_in  = dcnt_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      size_in  = size_ff;
      ov_in    = ov_ff & ~rsp_ready;
      o_hit_in = o_hit_ff;
      o_found_in = o_found_ff;
      o_fetch_in = o_fetch_ff;
      o_wt_in  = o_wt_ff;
      o_wb_in  = o_wb_ff;
      o_dv_in  = o_dv_ff;
      o_dp_in  = o_dp_ff;
      o_p_in   = o_p_ff;
      o_hc_in  = o_hc_ff;
      o_rc_in  = o_rc_ff;
      tag_we = 1'b0; tag_wa = cur_ff;
      meta_we = 1'b0; meta_wa = cur_ff; meta_wd = '0;
      nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0;
      prv_we = 1'b0; prv_wa = '0; prv_wd = '0;
      fs_we = 1'b0; fs_wa = sp_ff[IW-1:0]; fs_wd = cur_ff;
      raddr = cur_ff;
      code = FND_NONE;
      lsel = LST_T1;
      thr = 9'd1;
      rem_sh = '0;
      qv = '0;
      d_w = '0;
      pd_w = '0;
      req_ready = 1'b0;
      csr_ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            csr_ready = 1'b1;
            req_ready = ~csr_valid;
            if (csr_valid) begin
               // flush lists; slots at or above the fill count are not scanned
               cap_in = csr_capacity;
               p_in   = '0;
               nu_in  = '0;
               sp_in  = '0;
               for (int k = 0; k < 4; k++) begin
                  head_in[k] = '0;
                  tail_in[k] = '0;
                  size_in[k] = '0;
               end
            end else if (req_valid) begin
               page_in  = req_page;
               rd_in    = req_is_read;
               if (reqs_ff != 32'hFFFF_FFFF) reqs_in = reqs_ff + 32'd1;
               found_in = FND_NONE;
               scan_in  = '0;
               dem_v_in = 1'b0;
               dem_d_in = 1'b0;
               dem_pg_in = '0;
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // stream slots through the read port, compare one word behind
            raddr = scan_ff[IW-1:0];
            if (scan_ff < nu_ff) begin
               scan_in = scan_ff + SW'(1);
               cmpv_in = 1'b1;
               cmpi_in = scan_ff[IW-1:0];
            end
            if (cmpv_ff && meta_rd_ff[META_VALID] && tag_rd_ff == page_ff) begin
               code = 3'(meta_rd_ff[2:1]) + FND_T1;
               if (found_ff == FND_NONE || code < found_ff) begin
                  found_in = code;
                  slot_in  = cmpi_ff;
                  bmeta_in = meta_rd_ff;
               end
            end
            if (!(scan_ff < nu_ff) && !cmpv_ff) state_in = ST_DECIDE;
         end

         ST_DECIDE: begin
            if (found_ff == FND_T1 || found_ff == FND_T2) begin
               meta_we = 1'b1;
               meta_wa = slot_ff;
               meta_wd = bmeta_ff;
               meta_wd[META_REF] = 1'b1;
               if (!rd_ff) meta_wd[META_DIRTY] = 1'b1;
               if (hits_ff != 32'hFFFF_FFFF) hits_in = hits_ff + 32'd1;
               state_in = ST_OUT;
            end else if (s1_w + s2_w >= c_w) begin
               state_in = ST_SW_SEL;
            end else if (found_ff != FND_NONE) begin
               state_in = ST_DIV_INIT;
            end else begin
               state_in = ST_ALLOC;
            end
         end

         ST_SW_SEL: begin
            // pick the clock to advance
            if (s1_w == '0 && s2_w == '0) begin
               state_in = ST_AFTER;
            end else begin
               thr  = (p_ff > 9'd1) ? p_ff : 9'd1;
               lsel = (s1_w >= AW'(thr)) ? LST_T1 : LST_T2;
               if (size_ff[lsel] == '0) lsel = (lsel == LST_T1) ? LST_T2 : LST_T1;
               sl_in    = lsel;
               cur_in   = head_ff[lsel];
               op_in    = OP_SWEEP;
               state_in = ST_RD;
            end
         end

         ST_RD: begin
            raddr    = cur_ff;
            state_in = ST_UNL;
         end

         ST_UNL: begin
            // unlink the entry from its list
            if (size_ff[sl_ff] != '0) begin
               if (cur_ff == head_ff[sl_ff]) begin
                  head_in[sl_ff] = nxt_rd_ff;
               end else begin
                  nxt_we = 1'b1;
                  nxt_wa = prv_rd_ff;
                  nxt_wd = nxt_rd_ff;
               end
               if (cur_ff == tail_ff[sl_ff]) begin
                  tail_in[sl_ff] = prv_rd_ff;
               end else begin
                  prv_we = 1'b1;
                  prv_wa = nxt_rd_ff;
                  prv_wd = prv_rd_ff;
               end
               size_in[sl_ff] = size_ff[sl_ff] - SW'(1);
            end
            meta_we = 1'b1;
            meta_wa = cur_ff;
            case (op_ff)
               OP_SWEEP: begin
                  if (!meta_rd_ff[META_REF]) begin
                     lsel = (sl_ff == LST_T1) ? LST_B1 : LST_B2;
                     dem_v_in  = 1'b1;
                     dem_d_in  = meta_rd_ff[META_DIRTY];
                     dem_pg_in = tag_rd_ff;
                  end else begin
                     lsel = LST_T2;
                  end
                  meta_wd = {meta_rd_ff[META_DIRTY], 1'b0, lsel, 1'b1};
                  pl_in    = lsel;
                  state_in = ST_PUSH;
               end
               OP_DROP: begin
                  meta_wd = '0;
                  fs_we   = 1'b1;
                  fs_wa   = sp_ff[IW-1:0];
                  fs_wd   = cur_ff;
                  sp_in   = sp_ff + SW'(1);
                  state_in = ST_ALLOC;
               end
               OP_GHOST: begin
                  meta_wd  = {~rd_ff, 1'b0, LST_T2, 1'b1};
                  pl_in    = LST_T2;
                  state_in = ST_PUSH;
               end
               default: begin
                  meta_wd  = meta_rd_ff;
                  state_in = ST_OUT;
               end
            endcase
         end

         ST_PUSH: begin
            // append at the tail
            if (size_ff[pl_ff] == '0) begin
               head_in[pl_ff] = cur_ff;
            end else begin
               nxt_we = 1'b1;
               nxt_wa = tail_ff[pl_ff];
               nxt_wd = cur_ff;
               prv_we = 1'b1;
               prv_wa = cur_ff;
               prv_wd = tail_ff[pl_ff];
            end
            tail_in[pl_ff] = cur_ff;
            size_in[pl_ff] = size_ff[pl_ff] + SW'(1);
            if (op_ff == OP_ADMIT) begin
               tag_we  = 1'b1;
               tag_wa  = cur_ff;
               meta_we = 1'b1;
               meta_wa = cur_ff;
               meta_wd = {~rd_ff, 1'b0, LST_T1, 1'b1};
            end
            if (op_ff == OP_SWEEP) begin
               state_in = dem_v_ff ? ST_AFTER : ST_SW_SEL;
            end else begin
               state_in = ST_OUT;
            end
         end

         ST_AFTER: begin
            if (found_ff != FND_NONE) begin
               state_in = ST_DIV_INIT;
            end else if (s1_w + b1_w >= c_w && b1_w != '0) begin
               sl_in    = LST_B1;
               cur_in   = head_ff[LST_B1];
               op_in    = OP_DROP;
               state_in = ST_RD;
            end else if (sum_w >= {c_w[AW-2:0], 1'b0} && b2_w != '0) begin
               sl_in    = LST_B2;
               cur_in   = head_ff[LST_B2];
               op_in    = OP_DROP;
               state_in = ST_RD;
            end else begin
               state_in = ST_ALLOC;
            end
         end

         ST_DIV_INIT: begin
            if (found_ff == FND_B1) begin
               quo_in = size_ff[LST_B2];
               dvs_in = size_ff[LST_B1];
            end else begin
               quo_in = size_ff[LST_B1];
               dvs_in = size_ff[LST_B2];
            end
            rem_in   = '0;
            dcnt_in  = CW'(SW);
            state_in = ST_DIV;
         end

         ST_DIV: begin
            if (dcnt_ff != '0) begin
               // one restoring step per cycle
               rem_sh = {rem_ff[SW-1:0], quo_ff[SW-1]};
               quo_in = {quo_ff[SW-2:0], 1'b0};
               if (rem_sh >= {1'b0, dvs_ff}) begin
                  rem_sh    = rem_sh - {1'b0, dvs_ff};
                  quo_in[0] = 1'b1;
               end
               rem_in  = rem_sh;
               dcnt_in = dcnt_ff - CW'(1);
            end else begin
               qv  = (dvs_ff == '0) ? '0 : quo_ff;
               d_w = (qv == '0) ? AW'(1) : AW'(qv);
               if (found_ff == FND_B1) begin
                  pd_w = p_w + d_w;
                  p_in = (pd_w > c_w) ? c_eff : pd_w[8:0];
                  sl_in = LST_B1;
               end else begin
                  pd_w = p_w - d_w;
                  p_in = (p_w > d_w) ? pd_w[8:0] : 9'd0;
                  sl_in = LST_B2;
               end
               cur_in   = slot_ff;
               op_in    = OP_GHOST;
               state_in = ST_RD;
            end
         end

         ST_ALLOC: begin
            // recycle a freed slot, else take the next unused one, else admit nothing
            if (sp_ff != '0) begin
               raddr    = IW'(sp_ff - SW'(1));
               sp_in    = sp_ff - SW'(1);
               state_in = ST_ALLOC_RD;
            end else if (nu_ff < SLOTS_S) begin
               cur_in   = nu_ff[IW-1:0];
               nu_in    = nu_ff + SW'(1);
               op_in    = OP_ADMIT;
               pl_in    = LST_T1;
               state_in = ST_PUSH;
            end else begin
               state_in = ST_OUT;
            end
         end

         ST_ALLOC_RD: begin
            cur_in   = fs_rd_ff;
            op_in    = OP_ADMIT;
            pl_in    = LST_T1;
            state_in = ST_PUSH;
         end

         ST_OUT: begin
            // load the result word once the output register is free or being taken
            if (!ov_ff || rsp_ready) begin
               ov_in      = 1'b1;
               o_hit_in   = (found_ff == FND_T1 || found_ff == FND_T2);
               o_found_in = found_ff;
               o_fetch_in = ~(found_ff == FND_T1 || found_ff == FND_T2) & rd_ff;
               o_wt_in    = ~rd_ff;
               o_wb_in    = dem_v_ff & dem_d_ff;
               o_dv_in    = dem_v_ff;
               o_dp_in    = dem_v_ff ? dem_ext[31:0] : 32'd0;
               o_p_in     = p_ff;
               o_hc_in    = hits_ff;
               o_rc_in    = reqs_ff;
               state_in   = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid              = ov_ff;
   assign rsp_hit                = o_hit_ff;
   assign rsp_found_in           = o_found_ff;
   assign rsp_fetch_from_backing = o_fetch_ff;
   assign rsp_write_through      = o_wt_ff;
   assign rsp_writeback_dirty    = o_wb_ff;
   assign rsp_demoted_valid      = o_dv_ff;
   assign rsp_demoted_page       = o_dp_ff;
   assign rsp_target_p           = o_p_ff;
   assign rsp_hit_count          = o_hc_ff;
   assign rsp_request_count      = o_rc_ff;

`include "clock_adaptive_page_replacement_top_assert.svh"

   `CAPR_ASSERT_ALWAYS(a_p_le_cap, (p_ff <= c_eff), "target p above capacity")
   `CAPR_ASSERT_ALWAYS(a_fill_le_slots, (nu_ff <= SLOTS_S && sp_ff <= nu_ff),
      "slot fill count broken")
   `CAPR_ASSERT_NEXT(a_idle_lists, (state_ff == ST_IDLE && !csr_valid),
      (state_ff != ST_IDLE || sum_w == AW'(nu_ff - sp_ff)), "list sizes disagree with slots in use")
   `CAPR_ASSERT_NEXT(a_req_starts, (req_valid && req_ready), (state_ff == ST_SCAN),
      "accepted word did not start lookup")

endmodule
